// File: rtl/trilinear_volume_sampler_macros.svh
// Assertion macros for the trilinear volume sampler.
`ifndef TRILINEAR_VOLUME_SAMPLER_MACROS_SVH
`define TRILINEAR_VOLUME_SAMPLER_MACROS_SVH
`define TVS_ASSERT_IMPL(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error(msg);
`define TVS_ASSERT_NEXT(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error(msg);
`endif

// File: rtl/tvs_pkg.sv
// Shared types and codes of the trilinear volume sampler.
package tvs_pkg;
    localparam int CFG_W = 7;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OUT   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    typedef struct packed {
        logic        action;
        logic [17:0] voxel_address;
        logic [15:0] voxel_value;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [15:0] coord_z;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] sample_value;
        logic [1:0]  status;
    } t_out_beat;
endpackage

// File: rtl/tvs_bank.sv
// One voxel memory copy holding the whole volume, with a registered read.
module tvs_bank #(
    parameter int AW = 15,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tvs_lerp.sv
// Registered linear blend a*(1-f) + b*f with a pipeline enable.
module tvs_lerp #(
    parameter int IW = 16,
    parameter int FW = 10
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IW-1:0]    i_a,
    input  logic [IW-1:0]    i_b,
    input  logic [FW-1:0]    i_f,
    output logic [IW+FW-1:0] o_y
);
    logic [FW:0]     w_one_minus;
    logic [IW+FW:0]  w_sum;
    logic [IW+FW-1:0] r_y;

    assign w_one_minus = (FW+1)'(1 << FW) - {1'b0, i_f};
    assign w_sum = (IW+FW+1)'(i_a) * (IW+FW+1)'(w_one_minus)
                 + (IW+FW+1)'(i_b) * (IW+FW+1)'(i_f);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= w_sum[IW+FW-1:0];
        end
    end

    assign o_y = r_y;
endmodule

// File: rtl/trilinear_volume_sampler.sv
// Top level of the trilinear volume sampler: address, bank read, blend pipeline.
//
//   channel  | direction | handshake          | payload
//   input    | in        | i_valid / o_ready  | i_in  (t_in_beat)
//   output   | out       | o_valid / i_ready  | o_out (t_out_beat)
//   config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the output is not stalled; each beat passes stages 1 to 6 in order.
// Eight copies of the voxel memory, one per corner, give all eight corners in one read.
// Stage 1 checks bounds and splits coordinates, stage 2 forms corner addresses,
// stage 3 reads the copies, stages 4 to 6 blend x, y, z; the output takes the top bits.
// Reset clears valid bits and sets the sizes to 64; the voxel memory is undefined until written.
// A stall freezes the whole pipe.
module trilinear_volume_sampler #(
    parameter int DIM_MAX    = 64,
    parameter int VOXEL_BITS = 16,
    parameter int FRAC_BITS  = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tvs_pkg::t_in_beat           i_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output tvs_pkg::t_out_beat          o_out,
    input  logic                        i_cfg_we,
    input  logic [tvs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [tvs_pkg::CFG_W-1:0]   i_cfg_data
);
`include "trilinear_volume_sampler_macros.svh"

    localparam int DB  = $clog2(DIM_MAX);
    localparam int SW  = DB + 1;
    localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
    localparam int AW  = $clog2(DEPTH);
    localparam int W1  = VOXEL_BITS + FRAC_BITS;
    localparam int W2  = W1 + FRAC_BITS;
    localparam int W3  = W2 + FRAC_BITS;
    localparam int CW  = 16 - FRAC_BITS;

    logic [tvs_pkg::CFG_W-1:0] r_sx, r_sy, r_sz;
    logic adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= 7'd64;
            r_sy <= 7'd64;
            r_sz <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tvs_pkg::REG_SIZE_X: r_sx <= i_cfg_data;
                tvs_pkg::REG_SIZE_Y: r_sy <= i_cfg_data;
                tvs_pkg::REG_SIZE_Z: r_sz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [SW-1:0] eff(input logic [tvs_pkg::CFG_W-1:0] s);
        logic [SW-1:0] r;
        if (s == '0) r = SW'(1);
        else if (32'(s) > DIM_MAX) r = SW'(DIM_MAX);
        else r = SW'(s);
        return r;
    endfunction

    logic [SW-1:0] w_sx, w_sy, w_sz;
    assign w_sx = eff(r_sx);
    assign w_sy = eff(r_sy);
    assign w_sz = eff(r_sz);

    // stage 1: bounds, cell index, neighbour
    logic r1_v, r1_smp, r1_out, r1_wr;
    logic [AW-1:0] r1_waddr;
    logic [VOXEL_BITS-1:0] r1_wdata;
    logic [DB-1:0] r1_ix, r1_iy, r1_iz, r1_nx, r1_ny, r1_nz;
    logic [FRAC_BITS-1:0] r1_fx, r1_fy, r1_fz;

    logic w_outside;
    logic [CW:0] w_cix, w_ciy, w_ciz;
    assign w_cix = (CW+1)'(i_in.coord_x >> FRAC_BITS);
    assign w_ciy = (CW+1)'(i_in.coord_y >> FRAC_BITS);
    assign w_ciz = (CW+1)'(i_in.coord_z >> FRAC_BITS);
    assign w_outside =
        (32'(i_in.coord_x) > ((32'(w_sx) - 1) << FRAC_BITS)) ||
        (32'(i_in.coord_y) > ((32'(w_sy) - 1) << FRAC_BITS)) ||
        (32'(i_in.coord_z) > ((32'(w_sz) - 1) << FRAC_BITS));

    assign adv = i_ready || !o_valid;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_smp   <= (i_in.action == tvs_pkg::ACT_SAMPLE);
            r1_out   <= w_outside;
            r1_wr    <= i_valid && (i_in.action == tvs_pkg::ACT_WRITE)
                     && (32'(i_in.voxel_address) < DEPTH);
            r1_waddr <= AW'(i_in.voxel_address);
            r1_wdata <= VOXEL_BITS'(i_in.voxel_value);
            r1_ix <= DB'(w_cix);
            r1_iy <= DB'(w_ciy);
            r1_iz <= DB'(w_ciz);
            r1_nx <= (32'(w_cix) + 1 < 32'(w_sx)) ? DB'(w_cix + 1'b1) : DB'(w_cix);
            r1_ny <= (32'(w_ciy) + 1 < 32'(w_sy)) ? DB'(w_ciy + 1'b1) : DB'(w_ciy);
            r1_nz <= (32'(w_ciz) + 1 < 32'(w_sz)) ? DB'(w_ciz + 1'b1) : DB'(w_ciz);
            r1_fx <= i_in.coord_x[FRAC_BITS-1:0];
            r1_fy <= i_in.coord_y[FRAC_BITS-1:0];
            r1_fz <= i_in.coord_z[FRAC_BITS-1:0];
        end
    end

    // stage 2: linear corner addresses z*sx*sy + y*sx + x with the live sizes;
    // every copy takes every write, and copy k serves corner k.
    logic [AW-1:0] r2_ra [8];
    logic r2_v, r2_smp, r2_out;
    logic [FRAC_BITS-1:0] r2_fx, r2_fy, r2_fz;
    logic [2*SW-1:0] w_sxy;
    assign w_sxy = w_sx * w_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 8; k++) begin
                r2_ra[k] <= AW'(
                    32'((k & 4) != 0 ? r1_nz : r1_iz) * 32'(w_sxy)
                  + 32'((k & 2) != 0 ? r1_ny : r1_iy) * 32'(w_sx)
                  + 32'((k & 1) != 0 ? r1_nx : r1_ix));
            end
            r2_smp <= r1_smp;
            r2_out <= r1_out;
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_fz  <= r1_fz;
        end
    end

    // stage 3: read all eight copies
    logic [VOXEL_BITS-1:0] w_v [8];
    for (genvar g = 0; g < 8; g++) begin : g_bank
        tvs_bank #(.AW(AW), .DW(VOXEL_BITS)) u_bank (
            .i_clk  (i_clk),
            .i_we   (r1_wr && adv),
            .i_waddr(r1_waddr),
            .i_wdata(r1_wdata),
            .i_re   (adv),
            .i_raddr(r2_ra[g]),
            .o_rdata(w_v[g])
        );
    end

    logic r3_v, r3_smp, r3_out;
    logic [FRAC_BITS-1:0] r3_fy, r3_fz;
    logic [FRAC_BITS-1:0] r3_fx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_smp <= r2_smp;
            r3_out <= r2_out;
            r3_fx  <= r2_fx;
            r3_fy  <= r2_fy;
            r3_fz  <= r2_fz;
        end
    end

    // stage 4: x blend
    logic [W1-1:0] w_a [4];
    for (genvar g = 0; g < 4; g++) begin : g_lx
        tvs_lerp #(.IW(VOXEL_BITS), .FW(FRAC_BITS)) u_lerp (
            .i_clk(i_clk), .i_en(adv),
            .i_a(w_v[2*g]), .i_b(w_v[2*g+1]), .i_f(r3_fx), .o_y(w_a[g])
        );
    end
    logic r4_v, r4_smp, r4_out;
    logic [FRAC_BITS-1:0] r4_fy, r4_fz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_smp <= r3_smp;
            r4_out <= r3_out;
            r4_fy  <= r3_fy;
            r4_fz  <= r3_fz;
        end
    end

    // stage 5: y blend
    logic [W2-1:0] w_b [2];
    for (genvar g = 0; g < 2; g++) begin : g_ly
        tvs_lerp #(.IW(W1), .FW(FRAC_BITS)) u_lerp (
            .i_clk(i_clk), .i_en(adv),
            .i_a(w_a[2*g]), .i_b(w_a[2*g+1]), .i_f(r4_fy), .o_y(w_b[g])
        );
    end
    logic r5_v, r5_smp, r5_out;
    logic [FRAC_BITS-1:0] r5_fz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= r4_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_smp <= r4_smp;
            r5_out <= r4_out;
            r5_fz  <= r4_fz;
        end
    end

    // stage 6: z blend
    logic [W3-1:0] w_c;
    tvs_lerp #(.IW(W2), .FW(FRAC_BITS)) u_lz (
        .i_clk(i_clk), .i_en(adv),
        .i_a(w_b[0]), .i_b(w_b[1]), .i_f(r5_fz), .o_y(w_c)
    );
    logic r6_v, r6_smp, r6_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= r5_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_smp <= r5_smp;
            r6_out <= r5_out;
        end
    end

    logic [W3-3*FRAC_BITS-1:0] w_res;
    assign w_res = w_c[W3-1:3*FRAC_BITS];

    assign o_valid = r6_v;
    always_comb begin
        o_out.sample_value = '0;
        o_out.status = tvs_pkg::ST_WRITE;
        if (r6_smp && r6_out) begin
            o_out.status = tvs_pkg::ST_OUT;
        end else if (r6_smp) begin
            o_out.status = tvs_pkg::ST_OK;
            o_out.sample_value = 16'(w_res);
        end
    end

    `TVS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid,
        "output beat dropped under stall")
    `TVS_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !o_valid, o_ready,
        "pipe stalled with empty output")
    `TVS_ASSERT_IMPL(a_stat, i_clk, i_rst_n, o_valid && o_out.status != tvs_pkg::ST_OK,
        o_out.sample_value == '0, "nonzero value on non-sample result")
endmodule

// File: tb/sv/tb.sv
// Testbench for the trilinear volume sampler: random writes and samples checked against a predictor.
`timescale 1ns / 100ps

module tb;
    localparam int FRAC = 10;
    localparam int ONE = 1 << FRAC;
    localparam int LATENCY = 6;
    localparam int IN_W = $bits(tvs_pkg::t_in_beat);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    tvs_pkg::t_in_beat i_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    tvs_pkg::t_out_beat o_out;
    logic i_cfg_we = 1'b0;
    logic [tvs_pkg::IDX_W-1:0] i_cfg_index = tvs_pkg::REG_SIZE_X;
    logic [tvs_pkg::CFG_W-1:0] i_cfg_data = '0;

    tvs_pkg::t_in_beat pending_beats[$];
    tvs_pkg::t_out_beat expected_results[$];
    logic [15:0] voxel_mem[int];
    bit filled[int];
    logic [tvs_pkg::CFG_W-1:0] size_reg[3];
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_cnt = 0;
    bit hold_req = 1'b0;
    bit no_idle = 1'b0;
    int errors = 0;
    int n_ok = 0;
    int n_out = 0;
    int n_wr = 0;

    trilinear_volume_sampler dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int eff_size(logic [tvs_pkg::CFG_W-1:0] s);
        if (s == 0) return 1;
        if (s > 64) return 64;
        return int'(s);
    endfunction

    function automatic int voxel_addr(int x, int y, int z);
        return z * eff_size(size_reg[0]) * eff_size(size_reg[1]) +
               y * eff_size(size_reg[0]) + x;
    endfunction

    function automatic tvs_pkg::t_out_beat sample_voxels(tvs_pkg::t_in_beat b);
        tvs_pkg::t_out_beat r;
        int s[3];
        int c[3];
        int i[3];
        int n[3];
        longint f[3];
        longint w;
        longint total;
        int a;
        r = '0;
        if (b.action == tvs_pkg::ACT_WRITE) begin
            voxel_mem[int'(b.voxel_address)] = b.voxel_value;
            r.status = tvs_pkg::ST_WRITE;
            return r;
        end
        c[0] = int'(b.coord_x);
        c[1] = int'(b.coord_y);
        c[2] = int'(b.coord_z);
        for (int d = 0; d < 3; d++) begin
            s[d] = eff_size(size_reg[d]);
            if (c[d] > ((s[d] - 1) << FRAC)) begin
                r.status = tvs_pkg::ST_OUT;
                return r;
            end
            i[d] = c[d] >> FRAC;
            f[d] = c[d] & (ONE - 1);
            n[d] = (i[d] + 1 < s[d]) ? i[d] + 1 : i[d];
        end
        total = 0;
        for (int k = 0; k < 8; k++) begin
            w = (k[0] ? f[0] : ONE - f[0]) * (k[1] ? f[1] : ONE - f[1]) *
                (k[2] ? f[2] : ONE - f[2]);
            a = voxel_addr(k[0] ? n[0] : i[0], k[1] ? n[1] : i[1], k[2] ? n[2] : i[2]);
            if (voxel_mem.exists(a)) total += w * voxel_mem[a];
        end
        r.sample_value = 16'(total >> (3 * FRAC));
        r.status = tvs_pkg::ST_OK;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Driver: predict on acceptance, then offer the next beat or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) expected_results.push_back(sample_voxels(i_in));
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    i_in <= pending_beats.pop_front();
                    i_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    // Monitor: check each result beat, and drive ready with stalls.
    always @(posedge i_clk) begin
        tvs_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected beat", o_out.status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.status !== want.status)
                        report("status", o_out.status, want.status);
                    if (o_out.sample_value !== want.sample_value)
                        report("sample_value", o_out.sample_value, want.sample_value);
                    case (want.status)
                        tvs_pkg::ST_OK: n_ok++;
                        tvs_pkg::ST_OUT: n_out++;
                        default: n_wr++;
                    endcase
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt <= 300;
                i_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    task automatic push_write(int addr, logic [15:0] val);
        tvs_pkg::t_in_beat b;
        b = IN_W'({$urandom, $urandom, $urandom});
        b.action = tvs_pkg::ACT_WRITE;
        b.voxel_address = 18'(addr);
        b.voxel_value = val;
        pending_beats.push_back(b);
        filled[addr] = 1'b1;
    endtask

    // Write the corners of a cell that are still empty (and at random some already filled), then sample inside it.
    task automatic push_cell_sample(int ix, int iy, int iz, int fx, int fy, int fz);
        tvs_pkg::t_in_beat b;
        int i[3];
        int n[3];
        int a;
        i[0] = ix;
        i[1] = iy;
        i[2] = iz;
        for (int d = 0; d < 3; d++)
            n[d] = (i[d] + 1 < eff_size(size_reg[d])) ? i[d] + 1 : i[d];
        for (int k = 0; k < 8; k++) begin
            a = voxel_addr(k[0] ? n[0] : i[0], k[1] ? n[1] : i[1], k[2] ? n[2] : i[2]);
            if (!filled.exists(a) || $urandom_range(0, 5) == 0)
                push_write(a, 16'($urandom));
        end
        b = IN_W'({$urandom, $urandom, $urandom});
        b.action = tvs_pkg::ACT_SAMPLE;
        b.coord_x = 16'((ix << FRAC) | (ix == eff_size(size_reg[0]) - 1 ? 0 : fx));
        b.coord_y = 16'((iy << FRAC) | (iy == eff_size(size_reg[1]) - 1 ? 0 : fy));
        b.coord_z = 16'((iz << FRAC) | (iz == eff_size(size_reg[2]) - 1 ? 0 : fz));
        pending_beats.push_back(b);
    endtask

    task automatic push_outside(int axis);
        tvs_pkg::t_in_beat b;
        int lim;
        b = IN_W'({$urandom, $urandom, $urandom});
        b.action = tvs_pkg::ACT_SAMPLE;
        lim = ((eff_size(size_reg[axis]) - 1) << FRAC) + 1;
        case (axis)
            0: b.coord_x = 16'($urandom_range(lim, 65535));
            1: b.coord_y = 16'($urandom_range(lim, 65535));
            default: b.coord_z = 16'($urandom_range(lim, 65535));
        endcase
        pending_beats.push_back(b);
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_sizes(logic [tvs_pkg::CFG_W-1:0] sx, logic [tvs_pkg::CFG_W-1:0] sy,
                             logic [tvs_pkg::CFG_W-1:0] sz);
        logic [tvs_pkg::CFG_W-1:0] v[3];
        logic [tvs_pkg::IDX_W-1:0] idx[3];
        v = '{sx, sy, sz};
        idx = '{tvs_pkg::REG_SIZE_X, tvs_pkg::REG_SIZE_Y, tvs_pkg::REG_SIZE_Z};
        for (int d = 0; d < 3; d++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[d];
            i_cfg_data <= v[d];
            size_reg[d] = v[d];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_items(int count);
        int r;
        for (int j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                push_cell_sample($urandom_range(0, eff_size(size_reg[0]) - 1),
                                 $urandom_range(0, eff_size(size_reg[1]) - 1),
                                 $urandom_range(0, eff_size(size_reg[2]) - 1),
                                 $urandom_range(0, ONE - 1), $urandom_range(0, ONE - 1),
                                 $urandom_range(0, ONE - 1));
            else if (r < 75)
                push_outside($urandom_range(0, 2));
            else
                push_write($urandom_range(0, 262143), 16'($urandom));
        end
    endtask

    initial begin
        size_reg = '{7'd64, 7'd64, 7'd64};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes at reset sizes.
        push_write(0, 16'hFFFF);
        push_cell_sample(0, 0, 0, 0, 0, 0);
        push_cell_sample(0, 0, 0, ONE - 1, ONE - 1, ONE - 1);
        push_cell_sample(63, 63, 63, 0, 0, 0);
        push_cell_sample(62, 63, 10, 512, 0, 1);
        push_outside(0);
        push_outside(1);
        push_outside(2);
        push_write(262143, 16'h0000);
        push_cell_sample(63, 63, 63, 0, 0, 0);
        wait_idle();

        set_sizes(7'd1, 7'd1, 7'd1);
        push_cell_sample(0, 0, 0, 0, 0, 0);
        push_outside(0);
        push_outside(2);
        wait_idle();

        set_sizes(7'd0, 7'd127, 7'd2);
        no_idle = 1'b1;
        random_items(40);
        wait_idle();
        no_idle = 1'b0;

        set_sizes(7'd3, 7'd5, 7'd64);
        random_items(40);
        hold_req = 1'b1;
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            set_sizes(7'($urandom_range(0, 127)), 7'($urandom_range(1, 8)),
                      7'($urandom_range(0, 127)));
            random_items(20);
            wait_idle();
        end

        $display("Checked %0d in-grid samples, %0d outside-grid samples, %0d voxel writes",
                 n_ok, n_out, n_wr);
        $display("across 10 size settings including 0, 1, 64 and 127");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/tvs_pkg.sv
rtl/tvs_bank.sv
rtl/tvs_lerp.sv
rtl/trilinear_volume_sampler.sv
tb/sv/tb.sv
